>>> rtl/core/wspr_pkg.sv
// Package with shared types, constants and register indexes for the wheel speed PI ramp block.
package wspr_pkg;

   localparam int WHEELS      = 2;
   localparam int WHEEL_IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int SPEED_W     = 20;
   localparam int ERR_W       = 22;
   localparam int DIFF_W      = 23;
   localparam int PROD_W      = 40;
   localparam int ACC_W       = 41;
   localparam int DELTA_W     = ACC_W - 16;
   localparam int REQ_SUM_W   = DELTA_W + 1;
   localparam int DUTY_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE   = 3'd4;

   localparam logic [15:0] RST_MAX_DUTY      = 16'd4000;
   localparam logic [15:0] RST_RAMP_STEP     = 16'd80;
   localparam logic [15:0] RST_PROP_GAIN     = 16'd128;
   localparam logic [15:0] RST_INTEGRAL_GAIN = 16'd102;
   localparam logic [15:0] RST_SPEED_SCALE   = 16'd5026;

   typedef struct packed {
      logic [15:0] max_duty;
      logic [15:0] ramp_step;
      logic [15:0] prop_gain;
      logic [15:0] integral_gain;
      logic [15:0] speed_scale;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPEED,
      ST_ERR,
      ST_MUL,
      ST_DELTA,
      ST_CLAMP,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic speed_en;
      logic err_en;
      logic mul_en;
      logic delta_en;
      logic clamp_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/core/wspr_if.sv
// Handshake channel interfaces for the request and response beats.
interface wspr_req_if;
   logic        valid;
   logic        ready;
   logic        wheel;
   logic [15:0] pulse_count;
   logic [19:0] target_speed;

   modport source (output valid, output wheel, output pulse_count, output target_speed,
                   input ready);
   modport sink (input valid, input wheel, input pulse_count, input target_speed,
                 output ready);
endinterface

interface wspr_rsp_if;
   logic        valid;
   logic        ready;
   logic        wheel_out;
   logic [15:0] duty;

   modport source (output valid, output wheel_out, output duty, input ready);
   modport sink (input valid, input wheel_out, input duty, output ready);
endinterface

>>> rtl/core/wspr_csr.sv
// Configuration register file with reset values and indexed write port.
module wspr_csr
   import wspr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_DUTY:      cfg_in.max_duty      = csr_wdata;
            CSR_RAMP_STEP:     cfg_in.ramp_step     = csr_wdata;
            CSR_PROP_GAIN:     cfg_in.prop_gain     = csr_wdata;
            CSR_INTEGRAL_GAIN: cfg_in.integral_gain = csr_wdata;
            CSR_SPEED_SCALE:   cfg_in.speed_scale   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_duty      <= RST_MAX_DUTY;
         cfg_ff.ramp_step     <= RST_RAMP_STEP;
         cfg_ff.prop_gain     <= RST_PROP_GAIN;
         cfg_ff.integral_gain <= RST_INTEGRAL_GAIN;
         cfg_ff.speed_scale   <= RST_SPEED_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/wspr_ctrl.sv
// Sequencer that steps one beat through the PI datapath and waits on the output register.
module wspr_ctrl
   import wspr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            cmd.speed_en = 1'b1;
            state_in     = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_DELTA;
         end
         ST_DELTA: begin
            cmd.delta_en = 1'b1;
            state_in     = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Hold here until the output register can take the new duty.
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.rsp_free)
      else $error("commit while output register is full");

   a_load_starts_speed: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SPEED))
      else $error("accepted beat did not start the speed step");

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after commit");

endmodule

>>> rtl/core/wspr_dp.sv
// Datapath: speed scaling, PI delta, duty clamp and slew, per-wheel state and output register.
module wspr_dp
   import wspr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_wheel,
   input  logic [15:0] req_pulse_count,
   input  logic [19:0] req_target_speed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_wheel_out,
   output logic [15:0] rsp_duty
);

   // Captured request
   logic               wheel_ff;
   logic [15:0]        count_ff;
   logic [19:0]        target_ff;

   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]  pterm_ff, pterm_in;
   logic signed [PROD_W-1:0]  iterm_ff, iterm_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [DUTY_W-1:0]         req_duty_ff, req_duty_in;

   logic signed [ERR_W-1:0]   last_error_ff [WHEELS];
   logic [DUTY_W-1:0]         current_duty_ff [WHEELS];

   logic                      rsp_valid_ff;
   logic                      rsp_wheel_ff;
   logic [DUTY_W-1:0]         rsp_duty_ff;

   logic [WHEEL_IDX_W-1:0]    idx;
   logic [31:0]               speed_prod;
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-1:0]   acc_adj;
   logic signed [REQ_SUM_W-1:0] req_sum;
   logic signed [REQ_SUM_W-1:0] max_s;
   logic [DUTY_W-1:0]         cur;
   logic signed [DUTY_W+1:0]  up_lim;
   logic signed [DUTY_W+1:0]  dn_lim;
   logic signed [DUTY_W+1:0]  req_s;
   logic [DUTY_W-1:0]         next_duty;

   // Each wheel has its own state slot; with a single slot both wheels share it.
   assign idx = (WHEELS > 1) ? WHEEL_IDX_W'(wheel_ff) : '0;
   assign cur = current_duty_ff[idx];

   always_comb begin
      speed_prod = 32'(count_ff) * 32'(cfg.speed_scale);
      if (speed_prod[31:SPEED_W] != '0) begin
         speed_in = '1;
      end else begin
         speed_in = speed_prod[SPEED_W-1:0];
      end

      err_in  = $signed({2'b00, target_ff}) - $signed({2'b00, speed_ff});
      diff_in = DIFF_W'(err_in) - DIFF_W'(last_error_ff[idx]);

      pterm_in = PROD_W'($signed({1'b0, cfg.prop_gain})) * PROD_W'(diff_ff);
      iterm_in = PROD_W'($signed({1'b0, cfg.integral_gain})) * PROD_W'(err_ff);

      // Truncate the Q16 sum toward zero.
      acc      = ACC_W'(pterm_ff) + ACC_W'(iterm_ff);
      acc_adj  = acc + (acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
      delta_in = acc_adj[ACC_W-1:16];

      req_sum = $signed({{(REQ_SUM_W-DUTY_W){1'b0}}, cur}) + REQ_SUM_W'(delta_ff);
      max_s   = $signed({{(REQ_SUM_W-DUTY_W){1'b0}}, cfg.max_duty});
      if (req_sum > max_s) begin
         req_duty_in = cfg.max_duty;
      end else if (req_sum[REQ_SUM_W-1]) begin
         req_duty_in = '0;
      end else begin
         req_duty_in = req_sum[DUTY_W-1:0];
      end

      up_lim = $signed({2'b00, cur}) + $signed({2'b00, cfg.ramp_step});
      dn_lim = $signed({2'b00, cur}) - $signed({2'b00, cfg.ramp_step});
      req_s  = $signed({2'b00, req_duty_ff});
      if (req_s > up_lim) begin
         next_duty = up_lim[DUTY_W-1:0];
      end else if (req_s < dn_lim) begin
         next_duty = dn_lim[DUTY_W-1:0];
      end else begin
         next_duty = req_duty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wheel_ff  <= req_wheel;
         count_ff  <= req_pulse_count;
         target_ff <= req_target_speed;
      end
      if (cmd.speed_en) begin
         speed_ff <= speed_in;
      end
      if (cmd.err_en) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
      if (cmd.mul_en) begin
         pterm_ff <= pterm_in;
         iterm_ff <= iterm_in;
      end
      if (cmd.delta_en) begin
         delta_ff <= delta_in;
      end
      if (cmd.clamp_en) begin
         req_duty_ff <= req_duty_in;
      end
      if (cmd.commit) begin
         rsp_wheel_ff <= wheel_ff;
         rsp_duty_ff  <= next_duty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WHEELS; i++) begin
            last_error_ff[i]   <= '0;
            current_duty_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         last_error_ff[idx]   <= err_ff;
         current_duty_ff[idx] <= next_duty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_out   = rsp_wheel_ff;
   assign rsp_duty        = rsp_duty_ff;

endmodule

>>> rtl/core/wheel_speed_pi_ramp.sv
// Top level of the per-wheel incremental PI speed controller with duty clamp and slew.
// A request beat is taken only in idle and then passes the six sequencer steps, from speed
// to commit, before its response is registered and the next request beat can be taken.
// A response that is not taken stalls the sequencer at its commit step only.
// Reset is synchronous and active high; it loads register defaults and clears both wheels'
// stored error and duty, and leaves no response pending.
module wheel_speed_pi_ramp
   import wspr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   wspr_req_if.sink              req_ch,
   wspr_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // Register file; writes are expected only while the controller is idle.
   wspr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer walks each beat through speed, error, gain products, delta, clamp
   // and commit, one registered step per cycle, waiting at commit while the output is held.
   wspr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the per-wheel error and duty and the output register, so a
   // finished duty can wait for the sink while the next request is accepted.
   wspr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_wheel        (req_ch.wheel),
      .req_pulse_count  (req_ch.pulse_count),
      .req_target_speed (req_ch.target_speed),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_wheel_out    (rsp_ch.wheel_out),
      .rsp_duty         (rsp_ch.duty)
   );

   assign req_ch.ready = req_ready;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the per-wheel PI speed controller with duty clamp and slew.
`timescale 1ns / 1ps

module tb_top;
   import wspr_pkg::*;

   // Largest speed the block can represent; faster readings saturate here.
   localparam longint SPEED_LIMIT    = (64'd1 << SPEED_W) - 1;
   // Quiet cycles (nothing accepted on either channel) before the run is declared hung.
   localparam int     WATCHDOG_LIMIT = 2000;
   // Length of the deliberate response hold-off that backs up the block.
   localparam int     HOLD_CYCLES    = 200;
   // Cycles allowed after the last response before a register write or the end of run.
   localparam int     SETTLE_CYCLES  = 8;

   typedef struct {
      logic              wheel;
      logic [DUTY_W-1:0] duty;
   } wheel_duty_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wspr_req_if req_ch ();
   wspr_rsp_if rsp_ch ();

   wheel_speed_pi_ramp dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the configuration registers, updated on every write we issue.
   logic [15:0] duty_limit  = RST_MAX_DUTY;
   logic [15:0] slew_step   = RST_RAMP_STEP;
   logic [15:0] kp          = RST_PROP_GAIN;
   logic [15:0] ki          = RST_INTEGRAL_GAIN;
   logic [15:0] pulse_scale = RST_SPEED_SCALE;

   // Shadow copy of the per-wheel loop state: the previous error and the applied duty.
   logic signed [ERR_W-1:0] prev_error [WHEELS];
   logic [DUTY_W-1:0]       wheel_duty [WHEELS];

   // Duties the block owes us, oldest first.
   wheel_duty_type duty_expect_q[$];

   int fail_count   = 0;
   int quiet_cycles = 0;

   // Idling controls. The sender and receiver each insert random bursts of idle cycles
   // while their flag is set; hold_request asks the receiver for one long hold-off.
   bit req_idle_on  = 1'b0;
   bit rsp_idle_on  = 1'b0;
   bit hold_request = 1'b0;

   // One control period of the PI loop for the wheel in the beat. The speed is the
   // pulse count times the scale, saturated; the incremental delta is the Q16 product
   // sum truncated toward zero; the new duty is clamped to the limit and then kept
   // within one slew step of the old duty.
   function automatic void predict_duty(input logic wheel, input logic [15:0] count,
                                        input logic [19:0] target);
      logic [31:0]              raw_speed;
      logic [SPEED_W-1:0]       speed;
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic signed [ACC_W-1:0]  acc;
      logic [ACC_W-1:0]         mag;
      longint                   delta, cur, req, next;
      int                       idx;
      wheel_duty_type           beat;

      idx       = int'(wheel) % WHEELS;
      raw_speed = count * pulse_scale;
      speed     = (raw_speed > SPEED_LIMIT) ? SPEED_LIMIT[SPEED_W-1:0]
                                            : raw_speed[SPEED_W-1:0];
      err       = $signed({2'b00, target}) - $signed({2'b00, speed});
      diff      = err - prev_error[idx];
      acc       = $signed({1'b0, kp}) * diff + $signed({1'b0, ki}) * err;

      // Truncate toward zero: shift the magnitude, then restore the sign.
      mag   = acc[ACC_W-1] ? -acc : acc;
      delta = longint'(mag >> 16);
      if (acc[ACC_W-1])
         delta = -delta;

      cur = longint'(wheel_duty[idx]);
      req = cur + delta;
      if (req > longint'(duty_limit))
         req = longint'(duty_limit);
      if (req < 0)
         req = 0;

      if (req > cur + longint'(slew_step))
         next = cur + longint'(slew_step);
      else if (req < cur - longint'(slew_step))
         next = cur - longint'(slew_step);
      else
         next = req;

      prev_error[idx] = err;
      wheel_duty[idx] = next[DUTY_W-1:0];

      beat.wheel = wheel;
      beat.duty  = next[DUTY_W-1:0];
      duty_expect_q.push_back(beat);
   endfunction

   // Response checking. Every accepted response beat is matched against the oldest
   // predicted duty, field by field.
   always @(posedge clock) begin : check_duty
      wheel_duty_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (duty_expect_q.size() == 0) begin
            $error("response beat with nothing pending: wheel_out %0d duty %0d",
                   rsp_ch.wheel_out, rsp_ch.duty);
            fail_count++;
         end else begin
            want = duty_expect_q.pop_front();
            if (rsp_ch.wheel_out !== want.wheel) begin
               $error("wheel_out mismatch: expected %0d, actual %0d",
                      want.wheel, rsp_ch.wheel_out);
               fail_count++;
            end
            if (rsp_ch.duty !== want.duty) begin
               $error("duty mismatch: expected %0d, actual %0d", want.duty, rsp_ch.duty);
               fail_count++;
            end
         end
      end
   end

   // Watchdog. Any accepted beat on either channel restarts the count, so only a true
   // hang (or a hold-off far beyond the deliberate one) trips it.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Response receiver. Ready changes only at the falling edge. A hold request keeps
   // ready low for a long stretch counted here; otherwise random stall bursts appear
   // while idling is enabled.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Offer one request beat and wait for it to be taken. Valid is left high so that a
   // back-to-back beat needs only a payload change at the next falling edge.
   task automatic send_beat(input logic wheel, input logic [15:0] count,
                            input logic [19:0] target);
      int gap;
      gap = 0;
      if (req_idle_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.wheel        = wheel;
      req_ch.pulse_count  = count;
      req_ch.target_speed = target;
      do @(posedge clock); while (!req_ch.ready);
      predict_duty(wheel, count, target);
   endtask

   // Stop offering beats and wait until every predicted duty has come back, then let
   // the sequencer settle so the block is idle.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (duty_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      case (index)
         CSR_MAX_DUTY:      duty_limit  = data;
         CSR_RAMP_STEP:     slew_step   = data;
         CSR_PROP_GAIN:     kp          = data;
         CSR_INTEGRAL_GAIN: ki          = data;
         CSR_SPEED_SCALE:   pulse_scale = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Drain the block, then write all five registers.
   task automatic apply_settings(input logic [15:0] max_d, input logic [15:0] ramp,
                                 input logic [15:0] p_gain, input logic [15:0] i_gain,
                                 input logic [15:0] scale);
      wait_drained();
      write_register(CSR_MAX_DUTY, max_d);
      write_register(CSR_RAMP_STEP, ramp);
      write_register(CSR_PROP_GAIN, p_gain);
      write_register(CSR_INTEGRAL_GAIN, i_gain);
      write_register(CSR_SPEED_SCALE, scale);
   endtask

   // One random control period. Most periods have a pulse count close to what the
   // target asks for, so the loop actually regulates and the duty wanders inside its
   // range; the rest are fully random or sit at the count extremes.
   task automatic send_random_period();
      logic [19:0] target;
      int          count;
      int          pick;
      pick   = $urandom_range(0, 7);
      target = 20'($urandom_range(0, 20'hFFFFF));
      if (pick == 0) begin
         count = $urandom_range(0, 16'hFFFF);
      end else if (pick == 1) begin
         count = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 0;
      end else begin
         count = (pulse_scale == 0) ? $urandom_range(0, 16'hFFFF) : target / pulse_scale;
         count = count + int'($urandom_range(0, 8)) - 4;
         if (count < 0)
            count = 0;
         if (count > 16'hFFFF)
            count = 16'hFFFF;
      end
      send_beat(1'($urandom_range(0, 1)), count[15:0], target);
   endtask

   // Register defaults straight out of reset, with the field extremes on both wheels.
   task automatic test_reset_defaults();
      send_beat(1'b0, 16'd0, 20'hFFFFF);
      send_beat(1'b1, 16'd0, 20'hFFFFF);
      send_beat(1'b0, 16'hFFFF, 20'd0);
      send_beat(1'b1, 16'hFFFF, 20'hFFFFF);
      send_beat(1'b0, 16'd0, 20'd0);
      send_beat(1'b1, 16'd1, 20'd300);
   endtask

   // Speed saturation with the largest error swings, then small negative sums where
   // truncation toward zero differs from rounding down.
   task automatic test_saturation_and_truncation();
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(1'b1, 16'hFFFF, 20'd0);
      send_beat(1'b1, 16'd0, 20'hFFFFF);
      apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd1);
      send_beat(1'b0, 16'd3, 20'd0);
      send_beat(1'b0, 16'hFFFF, 20'd0);
   endtask

   // Duty clamp and slew: drive the duty to the top, then lower the limit below the
   // stored duty, try a zero limit and a zero slew step, and finally let it fall to 0.
   task automatic test_duty_limits();
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      send_beat(1'b0, 16'd0, 20'hFFFFF);
      apply_settings(16'd100, 16'd7, 16'hFFFF, 16'hFFFF, 16'd0);
      send_beat(1'b0, 16'd0, 20'hFFFFF);
      apply_settings(16'd0, 16'd7, 16'hFFFF, 16'hFFFF, 16'd0);
      send_beat(1'b0, 16'd0, 20'hFFFFF);
      apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_beat(1'b0, 16'd0, 20'hFFFFF);
      apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      send_beat(1'b0, 16'd0, 20'hFFFFF);
   endtask

   // Writes to indexes past the last register must leave the settings untouched.
   task automatic test_ignored_index();
      apply_settings(RST_MAX_DUTY, RST_RAMP_STEP, RST_PROP_GAIN, RST_INTEGRAL_GAIN,
                     RST_SPEED_SCALE);
      for (int i = int'(CSR_SPEED_SCALE) + 1; i < (1 << CSR_IDX_W); i++)
         write_register(i[CSR_IDX_W-1:0], 16'h0000);
      send_beat(1'b0, 16'd10, 20'd60000);
      send_beat(1'b1, 16'd100, 20'd20000);
      send_beat(1'b0, 16'd12, 20'd60000);
   endtask

   // Random periods over a series of settings: the reset values, every register at its top,
   // near-zero values, and random mixes. Idling is switched per phase, with some phases clean.
   task automatic test_random_settings();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_settings(RST_MAX_DUTY, RST_RAMP_STEP, RST_PROP_GAIN, RST_INTEGRAL_GAIN,
                              RST_SPEED_SCALE);
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: apply_settings(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
            default:
               apply_settings(16'($urandom_range(1, 16'hFFFF)),
                              16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16'hFFFF)
                                                              : $urandom_range(1, 500)),
                              16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1024)
                                                              : $urandom_range(0, 16'hFFFF)),
                              16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1024)
                                                              : $urandom_range(0, 16'hFFFF)),
                              16'($urandom_range(0, 16'hFFFF)));
         endcase
         req_idle_on = (phase % 3 != 2) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase % 3 != 2) && ($urandom_range(0, 3) != 0);
         repeat (110) send_random_period();
      end
   endtask

   // Hold the response side off for a long stretch while beats keep coming, so the
   // block fills and has to stall its request side.
   task automatic test_backpressure();
      apply_settings(16'd3000, 16'd200, 16'd300, 16'd200, 16'd900);
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b1;
      hold_request = 1'b1;
      repeat (60) send_random_period();
   endtask

   // The sender stops mid-stream until every result is back, then resumes.
   task automatic test_sender_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (30) send_random_period();
      wait_drained();
      repeat (30) send_random_period();
   endtask

   // Closing stretch at full rate with no idling on either side.
   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (100) send_random_period();
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.wheel        = 1'b0;
      req_ch.pulse_count  = '0;
      req_ch.target_speed = '0;
      for (int w = 0; w < WHEELS; w++) begin
         prev_error[w] = '0;
         wheel_duty[w] = '0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_saturation_and_truncation();
      test_duty_limits();
      test_ignored_index();
      test_random_settings();
      test_backpressure();
      test_sender_pause();
      test_full_rate();

      // Let the last responses drain, then watch a little longer for stray beats.
      wait_drained();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && duty_expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
